### rtl/lt_pkg.sv
`default_nettype none

package lt_pkg;

    // Default sizes of the block.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int PHASE_BITS_DEF  = 24;
    localparam int SINE_DEPTH_DEF  = 1024;

    // LFO values and gains are Q1.23.
    localparam int LFO_FRAC = 23;
    localparam int LFO_W    = LFO_FRAC + 1;
    localparam int LFO_SW   = LFO_FRAC + 2;
    localparam logic [LFO_SW-1:0] LFO_ONE = LFO_SW'(1) << LFO_FRAC;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Phase fraction points of the triangle and the sloped square, in Q23.
    localparam logic [LFO_SW-1:0] TRI_Q1  = LFO_SW'(2097152);
    localparam logic [LFO_SW-1:0] TRI_Q3  = LFO_SW'(6291456);
    localparam logic [LFO_SW-1:0] SQ_T48  = LFO_SW'(4026532);
    localparam logic [LFO_SW-1:0] SQ_T50  = LFO_SW'(4194304);
    localparam logic [LFO_SW-1:0] SQ_T98  = LFO_SW'(8220836);
    localparam logic [LFO_SW-1:0] SQ_SLOPE = LFO_SW'(50);
    localparam int SQ_EDGE_W = 18;

    // Depth in Q1.15.
    localparam int DEPTH_W = 16;
    localparam int DEPTH_FRAC = 15;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(32768);

    // Configuration registers.
    localparam int SHAPE_W    = 2;
    localparam int STEP_W     = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3);

    localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_RING   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic lfo_en;
        logic gain_en;
        logic mul_en;
        logic out_load;
    } t_cmd;

    // Sine over 0..pi/2 with the argument in Q30, result in Q23 clamped to 0..1.
    // Degree 13 Taylor series with each term truncated. Used only to build tables.
    function automatic logic [LFO_W-1:0] quarter_sine(input longint unsigned x);
        longint sum;
        longint unsigned term;
        sum  = longint'(x);
        term = x;
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64) >>> 7;
        if (sum > longint'(LFO_ONE)) begin
            sum = longint'(LFO_ONE);
        end
        return sum[LFO_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/lt_if.sv
`default_nettype none

interface lt_in_if #(
    parameter int SAMPLE_BITS = lt_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lt_out_if #(
    parameter int SAMPLE_BITS = lt_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface lt_cfg_if ();
    logic                            valid;
    logic                            ready;
    logic [lt_pkg::CFG_IDX_W-1:0]    idx;
    logic [lt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

### rtl/lt_sine_rom.sv
`default_nettype none

module lt_sine_rom #(
    parameter int SINE_TABLE_DEPTH = lt_pkg::SINE_DEPTH_DEF,
    parameter int ADDR_W           = $clog2(lt_pkg::SINE_DEPTH_DEF) - 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [ADDR_W-1:0]        i_addr,
    output logic      [lt_pkg::LFO_W-1:0] o_rise,
    output logic      [lt_pkg::LFO_W-1:0] o_fall
);
    import lt_pkg::*;

    localparam int QUARTER = SINE_TABLE_DEPTH / 4;

    // Rising and falling quarter waves; the second half of a period is the
    // negation of the first, which the datapath applies.
    logic [LFO_W-1:0] rise_tbl [QUARTER];
    logic [LFO_W-1:0] fall_tbl [QUARTER];
    logic [LFO_W-1:0] r_rise;
    logic [LFO_W-1:0] r_fall;

    for (genvar k = 0; k < QUARTER; k++) begin : g_tbl
        localparam longint unsigned X_K =
            (64'(4 * k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        assign rise_tbl[k] = quarter_sine(X_K);
        assign fall_tbl[k] = quarter_sine(HALF_PI_Q30 - X_K);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rise <= rise_tbl[i_addr];
            r_fall <= fall_tbl[i_addr];
        end
    end

    assign o_rise = r_rise;
    assign o_fall = r_fall;

endmodule

`default_nettype wire

### rtl/lt_cfg.sv
`default_nettype none

module lt_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lt_cfg_if.sink                          i_cfg,
    output logic      [lt_pkg::SHAPE_W-1:0] o_shape,
    output logic      [lt_pkg::DEPTH_W-1:0] o_depth,
    output logic      [lt_pkg::STEP_W-1:0]  o_step
);
    import lt_pkg::*;

    logic [SHAPE_W-1:0] r_shape;
    logic [DEPTH_W-1:0] r_depth;
    logic [STEP_W-1:0]  r_step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_SINE;
            r_depth <= '0;
            r_step  <= STEP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                REG_WAVE_SHAPE:   r_shape <= i_cfg.data[SHAPE_W-1:0];
                REG_DEPTH_AMOUNT: r_depth <= i_cfg.data[DEPTH_W-1:0];
                REG_PHASE_STEP:   r_step  <= i_cfg.data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_shape = r_shape;
    assign o_depth = r_depth;
    assign o_step  = r_step;

endmodule

`default_nettype wire

### rtl/lt_ctrl.sv
`default_nettype none

module lt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_out_ready,
    output logic              o_out_valid,
    output lt_pkg::t_cmd      o_cmd
);
    import lt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LFO  = 5'b00010,
        S_GAIN = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.lfo_en   = (r_state == S_LFO);
        o_cmd.gain_en  = (r_state == S_GAIN);
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LFO;
            end
            S_LFO:  n_state = S_GAIN;
            S_GAIN: n_state = S_MUL;
            S_MUL:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = accept ? S_LFO : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LFO))
        else $error("accepted transaction did not start the LFO step");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    a_gain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN) |-> $past(r_state == S_LFO))
        else $error("gain step not preceded by LFO step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LFO) || (r_state == S_GAIN) || (r_state == S_MUL)) |-> !accept)
        else $error("transaction accepted while an item is in flight");

endmodule

`default_nettype wire

### rtl/lt_dp.sv
`default_nettype none

module lt_dp #(
    parameter int SAMPLE_BITS      = lt_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS       = lt_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = lt_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lt_pkg::t_cmd                  i_cmd,
    input  wire logic        [lt_pkg::SHAPE_W-1:0] i_shape,
    input  wire logic        [lt_pkg::DEPTH_W-1:0] i_depth,
    input  wire logic        [lt_pkg::STEP_W-1:0]  i_step,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right,
    output logic      signed [SAMPLE_BITS-1:0] o_left,
    output logic      signed [SAMPLE_BITS-1:0] o_right
);
    import lt_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int K_W   = IDX_W - 2;
    localparam int PW    = SAMPLE_BITS + LFO_SW;
    localparam int RW    = PW - LFO_FRAC;
    localparam int GPW   = DEPTH_W + LFO_SW;
    localparam logic [RW-1:0] POS_LIM = (RW'(1) << (SAMPLE_BITS - 1)) - RW'(1);
    localparam logic [RW-1:0] NEG_LIM = RW'(1) << (SAMPLE_BITS - 1);
    localparam logic [PW-1:0] OUT_HALF = PW'(1) << (LFO_FRAC - 1);
    localparam logic [GPW-1:0] GAIN_HALF = GPW'(1) << (DEPTH_FRAC - 1);

    logic        [PHASE_BITS-1:0]  r_phase;
    logic        [LFO_FRAC-1:0]    frac;
    logic        [IDX_W-1:0]       idx;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic        [LFO_FRAC-1:0]    r_frac;
    logic        [1:0]             r_quad;
    logic        [LFO_W-1:0]       rise;
    logic        [LFO_W-1:0]       fall;

    // Phase accumulator and the item's operands.
    assign idx = r_phase[PHASE_BITS-1 -: IDX_W];

    if (PHASE_BITS >= LFO_FRAC) begin : g_frac_cut
        assign frac = r_phase[PHASE_BITS-1 -: LFO_FRAC];
    end else begin : g_frac_ext
        assign frac = {r_phase, {(LFO_FRAC - PHASE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= r_phase + PHASE_BITS'(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_frac  <= frac;
            r_quad  <= idx[IDX_W-1 -: 2];
        end
    end

    lt_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (K_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (i_cmd.accept),
        .i_addr (idx[K_W-1:0]),
        .o_rise (rise),
        .o_fall (fall)
    );

    // LFO value.
    logic        [LFO_W-1:0]      sine_mag;
    logic signed [LFO_SW-1:0]     sine_s;
    logic        [LFO_SW:0]       uni_sum;
    logic        [LFO_SW-1:0]     p;
    logic        [LFO_SW-1:0]     tri_v;
    logic        [SQ_EDGE_W-1:0]  edge_a;
    logic        [SQ_EDGE_W-1:0]  edge_b;
    logic        [LFO_SW-1:0]     slope_a;
    logic        [LFO_SW-1:0]     slope_b;
    logic        [LFO_SW-1:0]     sq_v;
    logic        [LFO_SW-1:0]     lfo_tmp_a;
    logic        [LFO_SW-1:0]     lfo_tmp_b;
    logic signed [LFO_SW-1:0]     n_lfo;
    logic signed [LFO_SW-1:0]     r_lfo;

    assign sine_mag = r_quad[0] ? fall : rise;
    assign sine_s   = r_quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
    assign uni_sum  = {sine_s[LFO_SW-1], sine_s} + (LFO_SW + 1)'(LFO_ONE);
    assign p        = LFO_SW'(r_frac);

    assign lfo_tmp_a = p - SQ_T48;
    assign lfo_tmp_b = p - SQ_T98;
    assign edge_a    = lfo_tmp_a[SQ_EDGE_W-1:0];
    assign edge_b    = lfo_tmp_b[SQ_EDGE_W-1:0];
    assign slope_a   = LFO_SW'(edge_a) * SQ_SLOPE;
    assign slope_b   = LFO_SW'(edge_b) * SQ_SLOPE;

    always_comb begin
        if (p < TRI_Q1) begin
            tri_v = (LFO_ONE >> 1) + (p << 1);
        end else if (p < TRI_Q3) begin
            tri_v = LFO_ONE - ((p - TRI_Q1) << 1);
        end else begin
            tri_v = (p - TRI_Q3) << 1;
        end
    end

    always_comb begin
        if (p < SQ_T48) begin
            sq_v = LFO_ONE;
        end else if (p < SQ_T50) begin
            sq_v = (slope_a > LFO_ONE) ? '0 : LFO_ONE - slope_a;
        end else if (p < SQ_T98) begin
            sq_v = '0;
        end else begin
            sq_v = (slope_b > LFO_ONE) ? LFO_ONE : slope_b;
        end
    end

    always_comb begin
        case (i_shape)
            SHAPE_TRI:    n_lfo = $signed(tri_v);
            SHAPE_SQUARE: n_lfo = $signed(sq_v);
            SHAPE_RING:   n_lfo = sine_s;
            SHAPE_SINE:   n_lfo = $signed(uni_sum[LFO_SW:1]);
            default:      n_lfo = $signed(uni_sum[LFO_SW:1]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lfo_en) begin
            r_lfo <= n_lfo;
        end
    end

    // Gain = 1 - depth * (1 - lfo), with depth clamped to full scale and the product rounded.
    logic        [DEPTH_W-1:0]  depth_c;
    logic        [LFO_SW:0]     diff;
    logic        [GPW-1:0]      gprod;
    logic        [GPW-1:0]      gsum;
    logic        [LFO_SW:0]     gain_w;
    logic signed [LFO_SW-1:0]   r_gain;

    assign depth_c = (i_depth > DEPTH_FULL) ? DEPTH_FULL : i_depth;
    assign diff    = (LFO_SW + 1)'(LFO_ONE) - {r_lfo[LFO_SW-1], r_lfo};
    assign gprod   = GPW'(depth_c) * GPW'(diff[LFO_SW-1:0]);
    assign gsum    = gprod + GAIN_HALF;
    assign gain_w  = (LFO_SW + 1)'(LFO_ONE) - {1'b0, gsum[DEPTH_FRAC +: LFO_SW]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_en) begin
            r_gain <= $signed(gain_w[LFO_SW-1:0]);
        end
    end

    // Sample times gain.
    logic signed [PW-1:0] r_prod_l;
    logic signed [PW-1:0] r_prod_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_l <= PW'(r_left) * PW'(r_gain);
            r_prod_r <= PW'(r_right) * PW'(r_gain);
        end
    end

    // Round half away from zero, then saturate to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [PW-1:0] prod
    );
        logic                          neg;
        logic        [PW-1:0]          mag;
        logic        [PW-1:0]          sum;
        logic        [RW-1:0]          rnd;
        logic        [RW-1:0]          neg_rnd;
        logic signed [SAMPLE_BITS-1:0] res;
        neg     = prod[PW-1];
        mag     = neg ? PW'(-prod) : PW'(prod);
        sum     = mag + OUT_HALF;
        rnd     = sum[PW-1:LFO_FRAC];
        neg_rnd = -rnd;
        if (!neg) begin
            res = (rnd > POS_LIM) ? $signed(POS_LIM[SAMPLE_BITS-1:0])
                                  : $signed(rnd[SAMPLE_BITS-1:0]);
        end else begin
            res = (rnd > NEG_LIM) ? $signed(NEG_LIM[SAMPLE_BITS-1:0])
                                  : $signed(neg_rnd[SAMPLE_BITS-1:0]);
        end
        return res;
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_left_out  <= round_sat(r_prod_l);
            r_right_out <= round_sat(r_prod_r);
        end
    end

    assign o_left  = r_left_out;
    assign o_right = r_right_out;

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_phase == $past(r_phase + PHASE_BITS'(i_step))))
        else $error("phase did not advance by one step on a transaction");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.accept |=> $stable(r_phase))
        else $error("phase moved without a transaction");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.gain_en) |-> ((r_gain <= $signed(LFO_ONE)) && (r_gain >= -$signed(LFO_ONE))))
        else $error("gain left the unit range");

endmodule

`default_nettype wire

### rtl/lfo_tremolo.sv
`default_nettype none
// An accepted input transaction passes through the four-step controller (LFO
// lookup, gain, multiply, round and load) to the output register. A new pair is
// taken while idle, or in the last pair's round and load step when the output is free.
// Reset (i_rst_n low at a clock edge) clears the LFO phase to zero, returns the
// controller to idle with no result pending and sets wave_shape 0, depth 0, step 3.

module lfo_tremolo #(
    parameter int SAMPLE_BITS      = lt_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS       = lt_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = lt_pkg::SINE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lt_in_if.sink     i_in,
    lt_out_if.source  o_out,
    lt_cfg_if.sink    i_cfg
);
    import lt_pkg::*;

    // The configuration registers sit in their own block. Writes are taken in every
    // cycle. Software must write only while no transaction is in flight; the block
    // does not enforce it, and the datapath reads them directly, without shadow copies.
    logic [SHAPE_W-1:0] shape;
    logic [DEPTH_W-1:0] depth;
    logic [STEP_W-1:0]  step;

    lt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_shape (shape),
        .o_depth (depth),
        .o_step  (step)
    );

    // The controller walks each item through its four steps and owns the
    // handshake. The output register decouples the two sides: while a finished
    // result waits for the downstream ready, the next input transaction may already
    // be accepted, and that item stalls only when its own result is due.
    t_cmd cmd;

    lt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the phase accumulator, the quarter-wave sine tables,
    // the LFO shaping, the depth multiply and the two sample multipliers with
    // rounding and saturation. The phase advances at each accepted transaction,
    // so the item uses the phase in effect before it arrived.
    lt_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_shape (shape),
        .i_depth (depth),
        .i_step  (step),
        .i_left  (i_in.left_sample),
        .i_right (i_in.right_sample),
        .o_left  (o_out.left_out),
        .o_right (o_out.right_out)
    );

endmodule

`default_nettype wire

### test/tb_lfo_tremolo.sv
`default_nettype none

// Self-checking bench for the stereo tremolo. A driver process feeds stereo pairs
// from a queue, and every accepted pair is run through a behavioral copy of the
// modulator here, which yields the expected output pair. A monitor process compares
// each output transaction with the oldest expected pair. Register writes happen only
// while nothing is in flight, so the bench's copy of the settings is always the one
// that the block uses.

module tb_lfo_tremolo;
    timeunit 1ns;
    timeprecision 1ps;

    import lt_pkg::*;

    localparam int SW        = SAMPLE_BITS_DEF;
    localparam int PW        = PHASE_BITS_DEF;
    localparam int LUT_DEPTH = SINE_DEPTH_DEF;

    // Q1.23 arithmetic constants of the modulator, with the quarter turn in Q30.
    localparam longint Q23_ONE          = 64'sd1 << 23;
    localparam longint FALL_START       = 64'sd4026532;
    localparam longint HALF_TURN        = 64'sd4194304;
    localparam longint RISE_START       = 64'sd8220836;
    localparam longint EDGE_SLOPE       = 64'sd50;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint SAMPLE_MAX       = (64'sd1 << (SW - 1)) - 1;
    localparam longint SAMPLE_MIN       = -SAMPLE_MAX - 1;

    // Register index that decodes to nothing; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_PAIRS = 700;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } t_stereo;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lt_in_if  #(.SAMPLE_BITS(SW)) pair_in ();
    lt_out_if #(.SAMPLE_BITS(SW)) pair_out ();
    lt_cfg_if                     reg_wr ();

    lfo_tremolo i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_in),
        .o_out   (pair_out),
        .i_cfg   (reg_wr)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the block's settings and LFO phase, at the block's widths.
    logic [SHAPE_W-1:0] lfo_shape = SHAPE_SINE;
    logic [DEPTH_W-1:0] lfo_depth = '0;
    logic [STEP_W-1:0]  lfo_step  = STEP_RESET;
    logic [PW-1:0]      lfo_phase = '0;

    // Q1.23 sine over one full turn, filled once at time zero.
    longint sine_lut [LUT_DEPTH];

    t_stereo pairs_to_send [$];
    t_stereo expected_out [$];

    // When set, neither side inserts any idle cycles.
    bit calm = 1'b0;

    int unsigned failures     = 0;
    int unsigned pairs_sent   = 0;
    int unsigned pairs_seen   = 0;
    int unsigned reg_writes   = 0;
    int unsigned phase_count  = 0;

    // Sine of x in Q30 over the first quadrant, by a degree 13 Taylor series with
    // every term truncated, then rounded to Q23 and clamped to 0..1.
    function automatic longint quarter_wave(longint unsigned x);
        longint acc;
        longint unsigned term;
        acc  = longint'(x);
        term = x;
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 64) >>> 7;
        if (acc > Q23_ONE) begin
            acc = Q23_ONE;
        end
        return acc;
    endfunction

    // LFO value in Q1.23 for one phase and wave shape. Shape codes that are not
    // triangle, square or ring fall back to the unipolar sine.
    function automatic longint lfo_level(logic [PW-1:0] phase, logic [SHAPE_W-1:0] shape);
        longint frac;
        longint level;
        int unsigned slot;
        slot = int'((longint'(phase) * LUT_DEPTH) >> PW);
        frac = longint'(phase >> (PW - 23));
        case (shape)
            SHAPE_TRI: begin
                if (frac < Q23_ONE / 4) begin
                    level = Q23_ONE / 2 + 2 * frac;
                end else if (frac < (3 * Q23_ONE) / 4) begin
                    level = Q23_ONE - 2 * (frac - Q23_ONE / 4);
                end else begin
                    level = 2 * (frac - (3 * Q23_ONE) / 4);
                end
            end
            SHAPE_SQUARE: begin
                // High until 48% of the turn, falling edge to 50%, low until 98%,
                // then a rising edge that wraps back into the high part.
                if (frac < FALL_START) begin
                    level = Q23_ONE;
                end else if (frac < HALF_TURN) begin
                    level = Q23_ONE - EDGE_SLOPE * (frac - FALL_START);
                end else if (frac < RISE_START) begin
                    level = 0;
                end else begin
                    level = EDGE_SLOPE * (frac - RISE_START);
                end
                if (level < 0) begin
                    level = 0;
                end
                if (level > Q23_ONE) begin
                    level = Q23_ONE;
                end
            end
            SHAPE_RING: begin
                level = sine_lut[slot];
            end
            default: begin
                level = (Q23_ONE + sine_lut[slot]) / 2;
            end
        endcase
        return level;
    endfunction

    // Sample times a Q1.23 gain, rounded half away from zero and saturated.
    function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s,
                                                         longint gain);
        longint prod;
        longint mag;
        longint r;
        prod = longint'(s) * gain;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'sd1 << 22)) >>> 23;
        r    = (prod < 0) ? -mag : mag;
        if (r > SAMPLE_MAX) begin
            r = SAMPLE_MAX;
        end
        if (r < SAMPLE_MIN) begin
            r = SAMPLE_MIN;
        end
        return r[SW-1:0];
    endfunction

    // Expected output for one accepted pair; advances the bench's LFO phase.
    function automatic t_stereo modulate(t_stereo x);
        longint d;
        longint gain;
        t_stereo y;
        // Depths above full scale behave as full depth.
        d = (lfo_depth > DEPTH_FULL) ? longint'(DEPTH_FULL) : longint'(lfo_depth);
        gain = Q23_ONE - (d * (Q23_ONE - lfo_level(lfo_phase, lfo_shape)) + 16384) / 32768;
        y.left  = scale_sample(x.left, gain);
        y.right = scale_sample(x.right, gain);
        // The accumulator wraps at the phase width.
        lfo_phase = lfo_phase + PW'(lfo_step);
        return y;
    endfunction

    function automatic void flag_failure(string what);
        failures++;
        if (failures <= 10) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SW'(SAMPLE_MIN);
            1:       return SW'(SAMPLE_MAX);
            2:       return SW'(int'($urandom_range(0, 16)) - 8);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic queue_pair(input longint l, input longint r);
        t_stereo p;
        p.left  = SW'(l);
        p.right = SW'(r);
        pairs_to_send = {pairs_to_send, p};
    endtask

    // One register write transaction. The bench copy of the settings follows the
    // block's register decode, including the dropped write to the spare index.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        reg_wr.valid <= 1'b1;
        reg_wr.idx   <= idx;
        reg_wr.data  <= value;
        do @(posedge i_clk); while (!reg_wr.ready);
        reg_wr.valid <= 1'b0;
        case (idx)
            REG_WAVE_SHAPE:   lfo_shape = value[SHAPE_W-1:0];
            REG_DEPTH_AMOUNT: lfo_depth = value[DEPTH_W-1:0];
            REG_PHASE_STEP:   lfo_step  = value[STEP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Blocks until the driver queue is drained and every expected pair has come
    // back. Sampled on the falling edge, where nothing is changing.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pairs_to_send.size() != 0 || pair_in.valid || expected_out.size() != 0);
    endtask

    // Input driver. A pair stays on the bus until accepted; after each acceptance
    // the next pair may wait out a random gap. The expected result is computed at
    // the acceptance edge, in the order that the block sees the pairs.
    t_stereo     held_pair;
    int unsigned send_gap;

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            pair_in.valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = pair_in.valid;
            if (pair_in.valid && pair_in.ready) begin
                expected_out = {expected_out, modulate(held_pair)};
                pairs_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pairs_to_send.size() != 0) begin
                    held_pair = pairs_to_send.pop_front();
                    pair_in.left_sample  <= held_pair.left;
                    pair_in.right_sample <= held_pair.right;
                    next_valid = 1'b1;
                    send_gap = calm ? 0 : idle_len();
                end
            end
            pair_in.valid <= next_valid;
        end
    end

    // Output monitor. Ready alternates between runs of acceptance and random stalls;
    // every output transaction is checked against the oldest expected pair.
    int unsigned ready_hold;

    always @(posedge i_clk) begin
        logic    next_ready;
        t_stereo want;
        if (!i_rst_n) begin
            pair_out.ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (pair_out.valid && pair_out.ready) begin
                pairs_seen++;
                if (expected_out.size() == 0) begin
                    flag_failure($sformatf("output pair (%0d, %0d) with none expected",
                                           pair_out.left_out, pair_out.right_out));
                end else begin
                    want = expected_out.pop_front();
                    if (pair_out.left_out !== want.left ||
                        pair_out.right_out !== want.right) begin
                        flag_failure($sformatf(
                            "pair %0d: left exp %0d got %0d, right exp %0d got %0d",
                            pairs_seen, want.left, pair_out.left_out,
                            want.right, pair_out.right_out));
                    end
                end
            end
            next_ready = pair_out.ready;
            if (calm) begin
                next_ready = 1'b1;
                ready_hold = 0;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else if (pair_out.ready) begin
                ready_hold = idle_len();
                next_ready = (ready_hold == 0);
            end else begin
                next_ready = 1'b1;
                ready_hold = $urandom_range(1, 40);
            end
            pair_out.ready <= next_ready;
        end
    end

    // Stimulus and end of run.
    initial begin
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned arg;
        longint mag;
        int unsigned random_queued;
        int unsigned burst;
        logic [CFG_DATA_W-1:0] noise;
        logic [DEPTH_W-1:0] depth_pick;
        logic [STEP_W-1:0] step_pick;

        pair_in.valid        = 1'b0;
        pair_in.left_sample  = '0;
        pair_in.right_sample = '0;
        pair_out.ready       = 1'b0;
        reg_wr.valid         = 1'b0;
        reg_wr.idx           = '0;
        reg_wr.data          = '0;

        // Full-turn table from the first quadrant: odd quadrants run backwards,
        // the second half of the turn is negated.
        for (int k = 0; k < LUT_DEPTH; k++) begin
            quad = (4 * k) / LUT_DEPTH;
            rem  = (4 * k) % LUT_DEPTH;
            arg  = (rem * QUARTER_TURN_Q30) / LUT_DEPTH;
            mag  = (quad % 2 == 1) ? quarter_wave(QUARTER_TURN_Q30 - arg) : quarter_wave(arg);
            sine_lut[k] = (quad >= 2) ? -mag : mag;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: zero depth, so the gain is exactly unity and the
        // samples must come through untouched, extremes included.
        phase_count++;
        queue_pair(SAMPLE_MAX, SAMPLE_MIN);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX);
        queue_pair(0, -1);
        queue_pair(longint'(24'h555555), -longint'(24'h2AAAAA));
        wait_idle();

        // Ring modulation at full depth with a quarter-turn step. The phase lands
        // on the start of each quadrant, so the gain goes to +1 and later to -1.
        // At -1 the most negative sample must saturate to the largest positive one,
        // and the fourth step carries the accumulator past its wrap point.
        phase_count++;
        write_reg(REG_WAVE_SHAPE, CFG_DATA_W'(SHAPE_RING));
        write_reg(REG_DEPTH_AMOUNT, CFG_DATA_W'(DEPTH_FULL));
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(1) << (PW - 2));
        repeat (4) queue_pair(SAMPLE_MIN, SAMPLE_MAX);
        wait_idle();

        // Triangle with a depth code above full scale and the unused data bits set.
        phase_count++;
        write_reg(REG_WAVE_SHAPE, CFG_DATA_W'(SHAPE_TRI));
        write_reg(REG_DEPTH_AMOUNT, '1);
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(1) << (PW - 3));
        queue_pair(SAMPLE_MAX, SAMPLE_MIN);
        queue_pair(12345, -12345);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX);
        queue_pair(-1, 1);
        wait_idle();

        // Sloped square. This step puts the second pair on the rising edge; a write
        // to the spare index follows and must leave every setting alone.
        phase_count++;
        write_reg(REG_WAVE_SHAPE, CFG_DATA_W'(SHAPE_SQUARE));
        write_reg(REG_DEPTH_AMOUNT, CFG_DATA_W'(DEPTH_FULL));
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(8100000));
        write_reg(REG_SPARE, '1);
        queue_pair(SAMPLE_MAX, SAMPLE_MAX);
        queue_pair(SAMPLE_MAX, SAMPLE_MIN);
        queue_pair(SAMPLE_MIN, SAMPLE_MIN);
        queue_pair(4000000, -4000000);
        wait_idle();

        // Random part: bursts of random pairs; before each burst every setting is redrawn
        // with a chance of three in four. Some bursts run with no idle cycles on either side.
        random_queued = 0;
        while (random_queued < RANDOM_PAIRS) begin
            phase_count++;
            noise = CFG_DATA_W'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_WAVE_SHAPE, CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       depth_pick = '0;
                    1:       depth_pick = DEPTH_FULL;
                    2:       depth_pick = DEPTH_W'($urandom_range(32769, 65535));
                    default: depth_pick = DEPTH_W'($urandom_range(0, 32768));
                endcase
                write_reg(REG_DEPTH_AMOUNT, {noise[CFG_DATA_W-1:DEPTH_W], depth_pick});
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       step_pick = '0;
                    1:       step_pick = '1;
                    2:       step_pick = STEP_W'($urandom_range(1, 70000));
                    default: step_pick = STEP_W'($urandom);
                endcase
                write_reg(REG_PHASE_STEP, step_pick);
            end
            if ($urandom_range(0, 4) == 0) begin
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            end
            calm  = ($urandom_range(0, 4) == 0);
            burst = $urandom_range(10, 60);
            for (int j = 0; j < burst; j++) begin
                queue_pair(pick_sample(), pick_sample());
            end
            random_queued += burst;
            wait_idle();
        end

        // Let a stray extra output show up, if there is one.
        calm = 1'b0;
        repeat (20) @(posedge i_clk);

        if (expected_out.size() != 0) begin
            $display("ERROR: %0d expected pairs never came out", expected_out.size());
            failures += expected_out.size();
        end

        $display("Ran %0d stereo pairs in %0d setting phases, %0d register writes.",
                 pairs_sent, phase_count, reg_writes);
        $display("Checked %0d output pairs, %0d failures.", pairs_seen, failures);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #6_000_000;
        $display("Watchdog expired with %0d pairs outstanding.", expected_out.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
